### src/frt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the free-running timer with compare/capture.
// No dependencies.
package frt_pkg;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_PRESET = 2'd1;
	localparam logic [1:0] REG_CAP_EN = 2'd2;

	localparam logic [15:0] BASE_RESET   = 16'h0008;
	localparam logic [15:0] PRESET_RESET = 16'hFFF8;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_PIN   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_WRITE = 2'd3;

	localparam logic [15:0] OFF_STATUS = 16'd0;
	localparam logic [15:0] OFF_CNT_HI = 16'd1;
	localparam logic [15:0] OFF_CNT_LO = 16'd2;
	localparam logic [15:0] OFF_CMP_HI = 16'd3;
	localparam logic [15:0] OFF_CMP_LO = 16'd4;
	localparam logic [15:0] OFF_CAP_HI = 16'd5;
	localparam logic [15:0] OFF_CAP_LO = 16'd6;

	// flag bit positions
	localparam int FLG_OVF = 0;
	localparam int FLG_CMP = 1;
	localparam int FLG_CAP = 2;

	// control bit positions
	localparam int CTL_LEVEL   = 0;
	localparam int CTL_RISING  = 1;
	localparam int CTL_IRQ_OVF = 2;
	localparam int CTL_IRQ_CMP = 3;
	localparam int CTL_IRQ_CAP = 4;

	localparam logic [1:0] IRQ_NONE = 2'd0;
	localparam logic [1:0] IRQ_CAP  = 2'd1;
	localparam logic [1:0] IRQ_CMP  = 2'd2;
	localparam logic [1:0] IRQ_OVF  = 2'd3;

	localparam logic [1:0] INHIBIT_CYCLES = 2'd1;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic        pin_value;
		logic        pin_known;
	} req_t;

	typedef struct packed {
		logic       handled;
		logic [7:0] read_data;
		logic       data_known;
		logic       irq_request;
		logic [1:0] irq_source;
		logic       irq_known;
		logic       compare_level;
		logic       compare_level_known;
	} rsp_t;

	typedef struct packed {
		logic [15:0] base_address;
		logic [15:0] counter_write_preset;
		logic        capture_enable;
	} cfg_t;

endpackage

### src/frt_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the timer.
// Depends on nothing; widths follow the request/result fields.
interface frt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        pin_value;
	logic        pin_known;

	modport source (output valid, action, address, write_data, pin_value, pin_known,
		input ready);
	modport sink (input valid, action, address, write_data, pin_value, pin_known,
		output ready);
endinterface

interface frt_rsp_if;
	logic       valid;
	logic       ready;
	logic       handled;
	logic [7:0] read_data;
	logic       data_known;
	logic       irq_request;
	logic [1:0] irq_source;
	logic       irq_known;
	logic       compare_level;
	logic       compare_level_known;

	modport source (output valid, handled, read_data, data_known, irq_request, irq_source,
		irq_known, compare_level, compare_level_known, input ready);
	modport sink (input valid, handled, read_data, data_known, irq_request, irq_source,
		irq_known, compare_level, compare_level_known, output ready);
endinterface

### src/free_running_timer_compare_capture.sv
`timescale 1ns / 1ps
// Top level of the 16-bit free-running timer with output compare and input capture.
// Depends on frt_pkg, frt_if, frt_cfg and frt_core.
//
// Each request (tick, capture pin update, bus read, bus write) yields one result: it is held in the request
// register, then the timer state and the result register update together when it leaves that register. A new
// request can be accepted every cycle while the result sink keeps up; throughput is one per clock, set by the
// state update in frt_core. The result register holds a finished result while the sink stalls, and the
// request register keeps taking requests until both are full. Configuration registers sit on the APB port at
// byte addresses 0, 4 and 8.
module free_running_timer_compare_capture (
	input  logic                       clk,
	input  logic                       arst_n,
	frt_req_if.sink                    req,
	frt_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [frt_pkg::APB_AW-1:0] paddr,
	input  logic [frt_pkg::APB_DW-1:0] pwdata,
	output logic [frt_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import frt_pkg::*;

	cfg_t cfg;
	req_t req_s1;
	logic vld_s1;
	rsp_t rsp_n;
	rsp_t rsp_s2;
	logic vld_s2;
	logic fire;

	frt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign fire      = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.action     <= req.action;
			req_s1.address    <= req.address;
			req_s1.write_data <= req.write_data;
			req_s1.pin_value  <= req.pin_value;
			req_s1.pin_known  <= req.pin_known;
		end
	end

	frt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (fire) begin
			vld_s2 <= 1'b1;
		end else if (rsp.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			rsp_s2 <= rsp_n;
	end

	assign rsp.valid               = vld_s2;
	assign rsp.handled             = rsp_s2.handled;
	assign rsp.read_data           = rsp_s2.read_data;
	assign rsp.data_known          = rsp_s2.data_known;
	assign rsp.irq_request         = rsp_s2.irq_request;
	assign rsp.irq_source          = rsp_s2.irq_source;
	assign rsp.irq_known           = rsp_s2.irq_known;
	assign rsp.compare_level       = rsp_s2.compare_level;
	assign rsp.compare_level_known = rsp_s2.compare_level_known;

endmodule

### src/frt_cfg.sv
`timescale 1ns / 1ps
// APB configuration registers: base address, counter preset, capture enable.
// Depends on frt_pkg.
module frt_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [frt_pkg::APB_AW-1:0] paddr,
	input  logic [frt_pkg::APB_DW-1:0] pwdata,
	output logic [frt_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output frt_pkg::cfg_t              cfg
);
	import frt_pkg::*;

	logic [15:0] base_q;
	logic [15:0] preset_q;
	logic        cap_en_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_RESET;
			preset_q <= PRESET_RESET;
			cap_en_q <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BASE:   base_q   <= pwdata[15:0];
				REG_PRESET: preset_q <= pwdata[15:0];
				REG_CAP_EN: cap_en_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BASE:   prdata = {16'd0, base_q};
			REG_PRESET: prdata = {16'd0, preset_q};
			REG_CAP_EN: prdata = {31'd0, cap_en_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.base_address         = base_q;
	assign cfg.counter_write_preset = preset_q;
	assign cfg.capture_enable       = cap_en_q;

endmodule

### src/frt_core.sv
`timescale 1ns / 1ps
// Timer state (counter, compare, capture, flags) and the combinational update
// for one request, registered on fire. Depends on frt_pkg.
module frt_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  frt_pkg::req_t req,
	input  frt_pkg::cfg_t cfg,
	output frt_pkg::rsp_t rsp
);
	import frt_pkg::*;

	logic [4:0]  ctl_q, ctl_n;
	logic [2:0]  flags_q, flags_n;
	logic [15:0] cnt_q, cnt_n;
	logic [7:0]  pend_hi_q, pend_hi_n;
	logic        hi_pend_q, hi_pend_n;
	logic [15:0] cmp_q, cmp_n;
	logic        lvl_q, lvl_n;
	logic        lvl_known_q, lvl_known_n;
	logic        cap_valid_q, cap_valid_n;
	logic [15:0] cap_q, cap_n;
	logic [2:0]  armed_q, armed_n;
	logic        stat_known_q, stat_known_n;
	logic [1:0]  inhibit_q, inhibit_n;
	logic        pin_lvl_q, pin_lvl_n;
	logic        pin_known_q, pin_known_n;

	logic [15:0] off;
	logic [15:0] cnt_inc;
	logic [7:0]  peek_data;
	logic        peek_known;
	logic        peek_hit;
	logic        hit;

	assign off     = req.address - cfg.base_address;
	assign cnt_inc = cnt_q + 16'd1;

	always_comb begin
		peek_data  = 8'd0;
		peek_known = 1'b1;
		peek_hit   = 1'b1;
		case (off)
			OFF_STATUS: begin
				peek_known = stat_known_q;
				peek_data  = stat_known_q ? {flags_q, ctl_q} : 8'd0;
			end
			OFF_CNT_HI: peek_data = cnt_q[15:8];
			OFF_CNT_LO: peek_data = cnt_q[7:0];
			OFF_CMP_HI: peek_data = cmp_q[15:8];
			OFF_CMP_LO: peek_data = cmp_q[7:0];
			OFF_CAP_HI: begin
				peek_known = cap_valid_q;
				peek_data  = cap_valid_q ? cap_q[15:8] : 8'd0;
			end
			OFF_CAP_LO: begin
				peek_known = cap_valid_q;
				peek_data  = cap_valid_q ? cap_q[7:0] : 8'd0;
			end
			default: begin
				peek_known = 1'b0;
				peek_hit   = 1'b0;
			end
		endcase
	end

	always_comb begin
		ctl_n        = ctl_q;
		flags_n      = flags_q;
		cnt_n        = cnt_q;
		pend_hi_n    = pend_hi_q;
		hi_pend_n    = hi_pend_q;
		cmp_n        = cmp_q;
		lvl_n        = lvl_q;
		lvl_known_n  = lvl_known_q;
		cap_valid_n  = cap_valid_q;
		cap_n        = cap_q;
		armed_n      = armed_q;
		stat_known_n = stat_known_q;
		inhibit_n    = inhibit_q;
		pin_lvl_n    = pin_lvl_q;
		pin_known_n  = pin_known_q;
		hit          = 1'b0;

		case (req.action)
			ACT_TICK: begin
				if (cfg.capture_enable && !pin_known_q) begin
					stat_known_n = 1'b0;
					cap_valid_n  = 1'b0;
					cap_n        = 16'd0;
				end
				cnt_n = cnt_inc;
				if (cnt_inc == 16'd0)
					flags_n[FLG_OVF] = 1'b1;
				if (inhibit_q != 2'd0) begin
					inhibit_n = inhibit_q - 2'd1;
				end else if (cnt_inc == cmp_q) begin
					flags_n[FLG_CMP] = 1'b1;
					lvl_n            = ctl_q[CTL_LEVEL];
					lvl_known_n      = 1'b1;
				end
			end
			ACT_PIN: begin
				if (!req.pin_known) begin
					pin_known_n = 1'b0;
					if (cfg.capture_enable) begin
						stat_known_n = 1'b0;
						cap_valid_n  = 1'b0;
						cap_n        = 16'd0;
					end
				end else if (!pin_known_q) begin
					pin_lvl_n   = req.pin_value;
					pin_known_n = 1'b1;
				end else begin
					pin_lvl_n = req.pin_value;
					// an edge is a change of level; rising iff the new level is high
					if (cfg.capture_enable && (pin_lvl_q != req.pin_value)
						&& (req.pin_value == ctl_q[CTL_RISING])) begin
						cap_n            = cnt_q;
						cap_valid_n      = 1'b1;
						stat_known_n     = 1'b1;
						flags_n[FLG_CAP] = 1'b1;
					end
				end
			end
			ACT_READ: begin
				hit = peek_hit;
				if (peek_hit && peek_known) begin
					if (off == OFF_STATUS) begin
						armed_n = flags_q;
					end else if (off == OFF_CNT_HI && armed_q[FLG_OVF]) begin
						flags_n[FLG_OVF] = 1'b0;
						armed_n[FLG_OVF] = 1'b0;
					end else if (off == OFF_CAP_HI && armed_q[FLG_CAP]) begin
						flags_n[FLG_CAP] = 1'b0;
						armed_n[FLG_CAP] = 1'b0;
					end
				end
			end
			ACT_WRITE: begin
				case (off)
					OFF_STATUS: begin
						hit   = 1'b1;
						ctl_n = req.write_data[4:0];
					end
					OFF_CNT_HI: begin
						hit       = 1'b1;
						pend_hi_n = req.write_data;
						hi_pend_n = 1'b1;
						cnt_n     = cfg.counter_write_preset;
						inhibit_n = INHIBIT_CYCLES;
					end
					OFF_CNT_LO: begin
						if (hi_pend_q) begin
							hit       = 1'b1;
							cnt_n     = {pend_hi_q, req.write_data};
							hi_pend_n = 1'b0;
							inhibit_n = INHIBIT_CYCLES;
						end
					end
					OFF_CMP_HI: begin
						hit       = 1'b1;
						cmp_n     = {req.write_data, cmp_q[7:0]};
						inhibit_n = INHIBIT_CYCLES;
						if (armed_q[FLG_CMP]) begin
							flags_n[FLG_CMP] = 1'b0;
							armed_n[FLG_CMP] = 1'b0;
						end
					end
					OFF_CMP_LO: begin
						hit   = 1'b1;
						cmp_n = {cmp_q[15:8], req.write_data};
						if (armed_q[FLG_CMP]) begin
							flags_n[FLG_CMP] = 1'b0;
							armed_n[FLG_CMP] = 1'b0;
						end
					end
					default: hit = 1'b0;
				endcase
			end
			default: hit = 1'b0;
		endcase
	end

	always_comb begin
		rsp.handled             = hit;
		rsp.data_known          = hit && peek_known;
		rsp.read_data           = (hit && peek_known) ? peek_data : 8'd0;
		rsp.irq_request         = 1'b0;
		rsp.irq_source          = IRQ_NONE;
		rsp.irq_known           = 1'b1;
		rsp.compare_level       = lvl_n;
		rsp.compare_level_known = lvl_known_n;
		if (ctl_n[CTL_IRQ_CAP] && flags_n[FLG_CAP]) begin
			rsp.irq_request = 1'b1;
			rsp.irq_source  = IRQ_CAP;
		end else if (ctl_n[CTL_IRQ_CAP] && !stat_known_n) begin
			rsp.irq_known = 1'b0;
		end else if (ctl_n[CTL_IRQ_CMP] && flags_n[FLG_CMP]) begin
			rsp.irq_request = 1'b1;
			rsp.irq_source  = IRQ_CMP;
		end else if (ctl_n[CTL_IRQ_OVF] && flags_n[FLG_OVF]) begin
			rsp.irq_request = 1'b1;
			rsp.irq_source  = IRQ_OVF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q        <= '0;
			flags_q      <= '0;
			cnt_q        <= '0;
			pend_hi_q    <= '0;
			hi_pend_q    <= 1'b0;
			cmp_q        <= 16'hFFFF;
			lvl_q        <= 1'b0;
			lvl_known_q  <= 1'b0;
			cap_valid_q  <= 1'b0;
			cap_q        <= '0;
			armed_q      <= '0;
			stat_known_q <= 1'b1;
			inhibit_q    <= '0;
			pin_lvl_q    <= 1'b0;
			pin_known_q  <= 1'b0;
		end else if (fire) begin
			ctl_q        <= ctl_n;
			flags_q      <= flags_n;
			cnt_q        <= cnt_n;
			pend_hi_q    <= pend_hi_n;
			hi_pend_q    <= hi_pend_n;
			cmp_q        <= cmp_n;
			lvl_q        <= lvl_n;
			lvl_known_q  <= lvl_known_n;
			cap_valid_q  <= cap_valid_n;
			cap_q        <= cap_n;
			armed_q      <= armed_n;
			stat_known_q <= stat_known_n;
			inhibit_q    <= inhibit_n;
			pin_lvl_q    <= pin_lvl_n;
			pin_known_q  <= pin_known_n;
		end
	end

	// an armed clear never outlives its flag
	a_armed_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q & ~flags_q) == 3'd0)
		else $error("clear armed for a flag that is not set");

	a_cap_implies_status: assert property (@(posedge clk) disable iff (!arst_n)
		cap_valid_q |-> stat_known_q)
		else $error("capture valid while status unknown");

	a_level_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(lvl_known_q))
		else $error("compare level lost its known state");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(cnt_q) && $stable(flags_q) && $stable(ctl_q))
		else $error("timer state changed without a request");

endmodule

### dv/free_running_timer_compare_capture_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for free_running_timer_compare_capture: a directed request table,
// then random tick/pin/bus request mixes under several timer settings, checked by a timer model.
// Depends on frt_pkg, frt_if and the RTL top level.
module free_running_timer_compare_capture_tb;
	import frt_pkg::*;

	localparam int CLK_HALF        = 6;
	localparam int RESET_CYCLES    = 3;
	localparam int LATENCY         = 2;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int ITEMS_PER_PHASE = 208;
	localparam int NUM_PHASES      = 6;
	localparam int PRINT_CAP       = 30;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t result;
	} vector_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	frt_req_if timer_req ();
	frt_rsp_if timer_rsp ();

	free_running_timer_compare_capture dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (timer_req),
		.rsp     (timer_rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #CLK_HALF clk = ~clk;

	// timer model state
	logic [4:0]  tm_ctl;
	logic [2:0]  tm_flags;
	logic [15:0] tm_cnt;
	logic [7:0]  tm_hi_byte;
	logic        tm_hi_pending;
	logic [15:0] tm_cmp;
	logic        tm_level;
	logic        tm_level_known;
	logic        tm_cap_valid;
	logic [15:0] tm_cap;
	logic [2:0]  tm_armed;
	logic        tm_status_known;
	logic [1:0]  tm_inhibit;
	logic        tm_pin;
	logic        tm_pin_known;
	cfg_t        tm_cfg;

	rsp_t    expected_results[$];
	vector_t directed[$];
	rsp_t    seen_rsp;
	rsp_t    want_rsp;
	int      src_idle_pct;
	int      snk_idle_pct;
	int      items_sent      = 0;
	int      results_checked = 0;
	int      mismatches      = 0;
	int      cycles;

	function automatic void lose_capture();
		tm_status_known = 1'b0;
		tm_cap_valid    = 1'b0;
		tm_cap          = '0;
	endfunction

	function automatic rsp_t timer_step(input req_t r);
		rsp_t        o;
		logic [15:0] off;
		logic        hit;
		logic        kn;
		logic        prev;
		logic [7:0]  d;
		o   = '0;
		hit = 1'b0;
		kn  = 1'b0;
		d   = '0;
		off = r.address - tm_cfg.base_address;
		case (r.action)
			ACT_TICK: begin
				if (tm_cfg.capture_enable && !tm_pin_known)
					lose_capture();
				tm_cnt = tm_cnt + 16'd1;
				if (tm_cnt == 16'd0)
					tm_flags[FLG_OVF] = 1'b1;
				if (tm_inhibit != 2'd0) begin
					tm_inhibit = tm_inhibit - 2'd1;
				end else if (tm_cnt == tm_cmp) begin
					tm_flags[FLG_CMP] = 1'b1;
					tm_level          = tm_ctl[CTL_LEVEL];
					tm_level_known    = 1'b1;
				end
			end
			ACT_PIN: begin
				if (!r.pin_known) begin
					tm_pin_known = 1'b0;
					if (tm_cfg.capture_enable)
						lose_capture();
				end else if (!tm_pin_known) begin
					tm_pin       = r.pin_value;
					tm_pin_known = 1'b1;
				end else begin
					prev   = tm_pin;
					tm_pin = r.pin_value;
					// with a change of level, a rising edge is one that ends high
					if (tm_cfg.capture_enable && prev != r.pin_value &&
							r.pin_value == tm_ctl[CTL_RISING]) begin
						tm_cap            = tm_cnt;
						tm_cap_valid      = 1'b1;
						tm_status_known   = 1'b1;
						tm_flags[FLG_CAP] = 1'b1;
					end
				end
			end
			ACT_READ: begin
				hit = 1'b1;
				kn  = 1'b1;
				case (off)
					OFF_STATUS: if (tm_status_known) d = {tm_flags, tm_ctl}; else kn = 1'b0;
					OFF_CNT_HI: d = tm_cnt[15:8];
					OFF_CNT_LO: d = tm_cnt[7:0];
					OFF_CMP_HI: d = tm_cmp[15:8];
					OFF_CMP_LO: d = tm_cmp[7:0];
					OFF_CAP_HI: if (tm_cap_valid) d = tm_cap[15:8]; else kn = 1'b0;
					OFF_CAP_LO: if (tm_cap_valid) d = tm_cap[7:0]; else kn = 1'b0;
					default: begin
						hit = 1'b0;
						kn  = 1'b0;
					end
				endcase
				if (hit && kn) begin
					if (off == OFF_STATUS) begin
						tm_armed = tm_flags;
					end else if (off == OFF_CNT_HI && tm_armed[FLG_OVF]) begin
						tm_flags[FLG_OVF] = 1'b0;
						tm_armed[FLG_OVF] = 1'b0;
					end else if (off == OFF_CAP_HI && tm_armed[FLG_CAP]) begin
						tm_flags[FLG_CAP] = 1'b0;
						tm_armed[FLG_CAP] = 1'b0;
					end
				end
			end
			ACT_WRITE: begin
				hit = 1'b1;
				kn  = 1'b1;
				case (off)
					OFF_STATUS: begin
						kn = tm_status_known;
						if (tm_status_known)
							d = {tm_flags, tm_ctl};
						tm_ctl = r.write_data[4:0];
					end
					OFF_CNT_HI: begin
						d             = tm_cnt[15:8];
						tm_hi_byte    = r.write_data;
						tm_hi_pending = 1'b1;
						tm_cnt        = tm_cfg.counter_write_preset;
						tm_inhibit    = INHIBIT_CYCLES;
					end
					OFF_CNT_LO: begin
						if (tm_hi_pending) begin
							d             = tm_cnt[7:0];
							tm_cnt        = {tm_hi_byte, r.write_data};
							tm_hi_pending = 1'b0;
							tm_inhibit    = INHIBIT_CYCLES;
						end else begin
							hit = 1'b0;
							kn  = 1'b0;
						end
					end
					OFF_CMP_HI: begin
						d            = tm_cmp[15:8];
						tm_cmp[15:8] = r.write_data;
						tm_inhibit   = INHIBIT_CYCLES;
					end
					OFF_CMP_LO: begin
						d           = tm_cmp[7:0];
						tm_cmp[7:0] = r.write_data;
					end
					default: begin
						hit = 1'b0;
						kn  = 1'b0;
					end
				endcase
				if ((off == OFF_CMP_HI || off == OFF_CMP_LO) && tm_armed[FLG_CMP]) begin
					tm_flags[FLG_CMP] = 1'b0;
					tm_armed[FLG_CMP] = 1'b0;
				end
			end
			default: ;
		endcase

		o.irq_known  = 1'b1;
		o.irq_source = IRQ_NONE;
		if (tm_ctl[CTL_IRQ_CAP] && tm_flags[FLG_CAP]) begin
			o.irq_request = 1'b1;
			o.irq_source  = IRQ_CAP;
		end else if (tm_ctl[CTL_IRQ_CAP] && !tm_status_known) begin
			o.irq_known = 1'b0;
		end else if (tm_ctl[CTL_IRQ_CMP] && tm_flags[FLG_CMP]) begin
			o.irq_request = 1'b1;
			o.irq_source  = IRQ_CMP;
		end else if (tm_ctl[CTL_IRQ_OVF] && tm_flags[FLG_OVF]) begin
			o.irq_request = 1'b1;
			o.irq_source  = IRQ_OVF;
		end
		o.handled             = hit;
		o.read_data           = (hit && kn) ? d : 8'h00;
		o.data_known          = hit && kn;
		o.compare_level       = tm_level;
		o.compare_level_known = tm_level_known;
		return o;
	endfunction

	function automatic rsp_t bus_result(input logic h, input logic [7:0] d, input logic k,
			input logic ik);
		rsp_t o;
		o            = '0;
		o.handled    = h;
		o.read_data  = d;
		o.data_known = k;
		o.irq_source = IRQ_NONE;
		o.irq_known  = ik;
		return o;
	endfunction

	task automatic add_vec(input logic [1:0] act, input logic [15:0] adr, input logic [7:0] wd,
			input logic pv, input logic pk, input bit typed, input rsp_t want);
		vector_t v;
		v.item.action     = act;
		v.item.address    = adr;
		v.item.write_data = wd;
		v.item.pin_value  = pv;
		v.item.pin_known  = pk;
		v.typed           = typed;
		v.result          = want;
		directed.push_back(v);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] mismatch on %s at result %0d: got %0h, expected %0h",
				$time, what, results_checked, got, want);
	endtask

	// called at a clock edge; returns at the edge where the request is taken
	task automatic send_item(input req_t r, input bit typed, input rsp_t typed_rsp);
		rsp_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			timer_req.valid <= 1'b0;
			@(posedge clk);
		end
		timer_req.valid      <= 1'b1;
		timer_req.action     <= r.action;
		timer_req.address    <= r.address;
		timer_req.write_data <= r.write_data;
		timer_req.pin_value  <= r.pin_value;
		timer_req.pin_known  <= r.pin_known;
		@(posedge clk);
		while (!timer_req.ready)
			@(posedge clk);
		predicted = timer_step(r);
		expected_results.push_back(typed ? typed_rsp : predicted);
		items_sent++;
	endtask

	task automatic issue(input logic [1:0] act, input logic [15:0] off, input logic [7:0] wd);
		req_t r;
		r.action     = act;
		r.address    = tm_cfg.base_address + off;
		r.write_data = wd;
		r.pin_value  = 1'($urandom_range(1));
		r.pin_known  = 1'($urandom_range(1));
		send_item(r, 1'b0, '0);
	endtask

	task automatic pin_item(input logic known);
		req_t r;
		r.action     = ACT_PIN;
		r.address    = 16'($urandom);
		r.write_data = 8'($urandom);
		r.pin_value  = 1'($urandom_range(1));
		r.pin_known  = known;
		send_item(r, 1'b0, '0);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
	endtask

	task automatic random_burst();
		int          kind;
		int          k;
		logic [15:0] aim;
		logic [7:0]  hi;
		kind = $urandom_range(99);
		if (kind < 28) begin
			repeat ($urandom_range(1, 8)) issue(ACT_TICK, 16'($urandom), 8'($urandom));
		end else if (kind < 37) begin
			// status read arms, counter high read clears overflow
			issue(ACT_READ, OFF_STATUS, 8'($urandom));
			issue(ACT_READ, OFF_CNT_HI, 8'($urandom));
			if ($urandom_range(1))
				issue(ACT_READ, OFF_CNT_LO, 8'($urandom));
		end else if (kind < 45) begin
			issue(ACT_READ, OFF_STATUS, 8'($urandom));
			issue(ACT_READ, OFF_CAP_HI, 8'($urandom));
			issue(ACT_READ, OFF_CAP_LO, 8'($urandom));
		end else if (kind < 52) begin
			issue(ACT_READ, OFF_STATUS, 8'($urandom));
			if ($urandom_range(1))
				issue(ACT_WRITE, OFF_CMP_HI, 8'($urandom));
			issue(ACT_WRITE, OFF_CMP_LO, 8'($urandom));
		end else if (kind < 62) begin
			// counter load, often just short of the wrap
			hi = $urandom_range(1) ? 8'hFF : 8'($urandom);
			issue(ACT_WRITE, OFF_CNT_HI, hi);
			if ($urandom_range(4) != 0)
				issue(ACT_WRITE, OFF_CNT_LO,
					(hi == 8'hFF) ? 8'($urandom_range(8'hF0, 8'hFF)) : 8'($urandom));
			repeat ($urandom_range(1, 16)) issue(ACT_TICK, 16'($urandom), 8'($urandom));
		end else if (kind < 70) begin
			// compare a few ticks ahead of the counter
			k   = $urandom_range(1, 6);
			aim = tm_cnt + 16'(k);
			issue(ACT_WRITE, OFF_CMP_HI, aim[15:8]);
			issue(ACT_WRITE, OFF_CMP_LO, aim[7:0]);
			repeat (k + 1) issue(ACT_TICK, 16'($urandom), 8'($urandom));
		end else if (kind < 79) begin
			repeat ($urandom_range(1, 4)) pin_item(1'b1);
		end else if (kind < 82) begin
			pin_item(1'b0);
			repeat ($urandom_range(0, 2)) issue(ACT_TICK, 16'($urandom), 8'($urandom));
			pin_item(1'b1);
		end else if (kind < 88) begin
			issue(ACT_WRITE, OFF_STATUS, 8'($urandom));
		end else if (kind < 95) begin
			issue($urandom_range(1) ? ACT_READ : ACT_WRITE, 16'($urandom_range(0, 7)),
				8'($urandom));
		end else begin
			issue(2'($urandom), 16'($urandom), 8'($urandom));
		end
	endtask

	initial timer_rsp.ready = 1'b0;

	always @(posedge clk) begin
		if (arst_n && timer_rsp.valid && timer_rsp.ready) begin
			seen_rsp = {timer_rsp.handled, timer_rsp.read_data, timer_rsp.data_known,
				timer_rsp.irq_request, timer_rsp.irq_source, timer_rsp.irq_known,
				timer_rsp.compare_level, timer_rsp.compare_level_known};
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request pending", 1, 0);
			end else begin
				want_rsp = expected_results.pop_front();
				results_checked++;
				if (seen_rsp.handled != want_rsp.handled)
					report_mismatch("handled", seen_rsp.handled, want_rsp.handled);
				if (seen_rsp.read_data != want_rsp.read_data)
					report_mismatch("read_data", seen_rsp.read_data, want_rsp.read_data);
				if (seen_rsp.data_known != want_rsp.data_known)
					report_mismatch("data_known", seen_rsp.data_known, want_rsp.data_known);
				if (seen_rsp.irq_request != want_rsp.irq_request)
					report_mismatch("irq_request", seen_rsp.irq_request, want_rsp.irq_request);
				if (seen_rsp.irq_source != want_rsp.irq_source)
					report_mismatch("irq_source", seen_rsp.irq_source, want_rsp.irq_source);
				if (seen_rsp.irq_known != want_rsp.irq_known)
					report_mismatch("irq_known", seen_rsp.irq_known, want_rsp.irq_known);
				if (seen_rsp.compare_level != want_rsp.compare_level)
					report_mismatch("compare_level", seen_rsp.compare_level,
						want_rsp.compare_level);
				if (seen_rsp.compare_level_known != want_rsp.compare_level_known)
					report_mismatch("compare_level_known", seen_rsp.compare_level_known,
						want_rsp.compare_level_known);
			end
		end
		timer_rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles, %0d results outstanding", cycles,
			expected_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int   p;
		int   target;
		cfg_t next_cfg;
		timer_req.valid      = 1'b0;
		timer_req.action     = ACT_TICK;
		timer_req.address    = '0;
		timer_req.write_data = '0;
		timer_req.pin_value  = 1'b0;
		timer_req.pin_known  = 1'b0;

		tm_ctl          = '0;
		tm_flags        = '0;
		tm_cnt          = '0;
		tm_hi_byte      = '0;
		tm_hi_pending   = 1'b0;
		tm_cmp          = 16'hFFFF;
		tm_level        = 1'b0;
		tm_level_known  = 1'b0;
		tm_cap_valid    = 1'b0;
		tm_cap          = '0;
		tm_armed        = '0;
		tm_status_known = 1'b1;
		tm_inhibit      = '0;
		tm_pin          = 1'b0;
		tm_pin_known    = 1'b0;
		tm_cfg          = '{BASE_RESET, PRESET_RESET, 1'b1};
		src_idle_pct    = 38;
		snk_idle_pct    = 76;

		add_vec(ACT_READ, BASE_RESET + OFF_STATUS, 8'h00, 1'b0, 1'b1, 1'b1,
			bus_result(1'b1, 8'h00, 1'b1, 1'b1));
		add_vec(ACT_READ, BASE_RESET + OFF_CNT_HI, 8'hFF, 1'b1, 1'b0, 1'b1,
			bus_result(1'b1, 8'h00, 1'b1, 1'b1));
		add_vec(ACT_READ, BASE_RESET + OFF_CMP_HI, 8'h00, 1'b0, 1'b0, 1'b1,
			bus_result(1'b1, 8'hFF, 1'b1, 1'b1));
		add_vec(ACT_READ, BASE_RESET + OFF_CAP_HI, 8'h00, 1'b0, 1'b0, 1'b1,
			bus_result(1'b1, 8'h00, 1'b0, 1'b1));
		add_vec(ACT_READ, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1,
			bus_result(1'b0, 8'h00, 1'b0, 1'b1));
		add_vec(ACT_READ, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1,
			bus_result(1'b0, 8'h00, 1'b0, 1'b1));
		// low counter byte with no high byte pending is ignored
		add_vec(ACT_WRITE, BASE_RESET + OFF_CNT_LO, 8'hFF, 1'b0, 1'b0, 1'b1,
			bus_result(1'b0, 8'h00, 1'b0, 1'b1));
		// unknown pin at a tick leaves the status unknown
		add_vec(ACT_TICK, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1,
			bus_result(1'b0, 8'h00, 1'b0, 1'b1));
		add_vec(ACT_READ, BASE_RESET + OFF_STATUS, 8'h00, 1'b0, 1'b0, 1'b1,
			bus_result(1'b1, 8'h00, 1'b0, 1'b1));
		add_vec(ACT_WRITE, BASE_RESET + OFF_STATUS, 8'hFF, 1'b0, 1'b0, 1'b1,
			bus_result(1'b1, 8'h00, 1'b0, 1'b0));
		add_vec(ACT_PIN, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, '0);
		add_vec(ACT_PIN, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b0, '0);
		add_vec(ACT_READ, BASE_RESET + OFF_STATUS, 8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_vec(ACT_READ, BASE_RESET + OFF_CAP_HI, 8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_vec(ACT_WRITE, BASE_RESET + OFF_CMP_HI, 8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_vec(ACT_WRITE, BASE_RESET + OFF_CMP_LO, 8'h04, 1'b0, 1'b0, 1'b0, '0);
		add_vec(ACT_WRITE, BASE_RESET + OFF_CNT_HI, 8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_vec(ACT_WRITE, BASE_RESET + OFF_CNT_LO, 8'h02, 1'b0, 1'b0, 1'b0, '0);
		add_vec(ACT_TICK, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, '0);
		add_vec(ACT_TICK, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, '0);
		add_vec(ACT_WRITE, BASE_RESET + OFF_CNT_HI, 8'hFF, 1'b0, 1'b0, 1'b0, '0);
		add_vec(ACT_WRITE, BASE_RESET + OFF_CNT_LO, 8'hFF, 1'b0, 1'b0, 1'b0, '0);
		add_vec(ACT_TICK, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b0, '0);
		add_vec(ACT_WRITE, BASE_RESET + OFF_STATUS, 8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_vec(ACT_PIN, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, '0);
		add_vec(ACT_PIN, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].item, directed[i].typed, directed[i].result);

		for (p = 0; p < NUM_PHASES; p++) begin
			timer_req.valid <= 1'b0;
			while (expected_results.size() != 0)
				@(posedge clk);
			repeat (LATENCY + 2) @(posedge clk);
			case (p)
				0: next_cfg = '{16'h0000, 16'hFFFF, 1'b1};
				1: next_cfg = '{16'hFFF8, 16'h0000, 1'b0};
				2: next_cfg = '{16'($urandom_range(65528)), 16'($urandom), 1'b1};
				3: next_cfg = '{BASE_RESET, PRESET_RESET, 1'b0};
				4: next_cfg = '{16'h1234, 16'hFFFE, 1'b1};
				default: next_cfg = '{16'($urandom_range(65528)), 16'($urandom),
					1'($urandom_range(1))};
			endcase
			apb_write(REG_BASE, 32'(next_cfg.base_address));
			apb_write(REG_PRESET, 32'(next_cfg.counter_write_preset));
			apb_write(REG_CAP_EN, 32'(next_cfg.capture_enable));
			psel    <= 1'b0;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			tm_cfg = next_cfg;
			case (p / 2)
				0: begin
					src_idle_pct = 38;
					snk_idle_pct = 76;
				end
				1: begin
					src_idle_pct = 76;
					snk_idle_pct = 38;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target)
				random_burst();
		end

		timer_req.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		$display("Run covered %0d requests: directed table, then tick/pin/bus mixes under %0d %s",
			items_sent, NUM_PHASES, "timer settings, with and without stalls on either side");
		$display("%0d results compared, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
